/* hdl/torque_friction_blend_assert.svh */
// ----------------------------------------------------------------------------
// Torque friction blend assertion macros
// Shared concurrent assertion macros for the torque friction blend RTL.
// ----------------------------------------------------------------------------
`ifndef TORQUE_FRICTION_BLEND_ASSERT_SVH
`define TORQUE_FRICTION_BLEND_ASSERT_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define TFB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("torque_friction_blend: invariant violated");

// When the antecedent holds, the consequent holds at the same edge.
`define TFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("torque_friction_blend: implication violated");

// When the antecedent holds, the consequent holds at the next edge.
`define TFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("torque_friction_blend: next-cycle check violated");

`else

`define TFB_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define TFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/tfb_pkg.sv */
// ----------------------------------------------------------------------------
// Torque friction blend package
// Beat types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tfb_pkg;

    // One input beat: two control voltages and the filtered motor velocity.
    typedef struct packed {
        logic signed [15:0] cv0_sample;
        logic signed [15:0] cv1_sample;
        logic signed [23:0] motor_velocity;
    } in_t;

    // One result beat: drive torque and the two peak followers.
    typedef struct packed {
        logic signed [19:0] drive_torque;
        logic        [18:0] torque_peak_high;
        logic signed [19:0] torque_peak_low;
    } out_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CV0_GAIN_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CV1_MODE        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ALPHA    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INDICATOR_ALPHA = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_GAIN    = 3'd4;

    localparam logic [15:0] FILTER_ALPHA_RESET    = 16'd655;
    localparam logic [15:0] INDICATOR_ALPHA_RESET = 16'd1311;
    localparam logic [15:0] DAMPING_GAIN_RESET    = 16'd256;

    // Unity in Q.15 and the saturation limits of the Q5.15 torque.
    localparam logic signed [16:0] ONE_Q15    = 17'sd32768;
    localparam logic signed [16:0] NEG_ONE_Q15 = -17'sd32768;
    localparam logic signed [19:0] TORQUE_MAX = 20'sd524287;
    localparam logic signed [19:0] TORQUE_MIN = -20'sd524288;

endpackage

`default_nettype wire

/* hdl/torque_friction_blend.sv */
// An accepted beat's result is loaded into the output register by the last step, S_WB_PKL.
// The single shared 33x18 multiplier runs seven products in sequence and the block
//   takes no new beat until the current one is done.
// A result waiting in the output register stalls only the last step, not the output side.
// Reset (rst_n low, asynchronous): filters and peak followers clear to zero and the
//   configuration registers return to their defaults (655, 1311, 256, modes zero).
`default_nettype none

`include "torque_friction_blend_assert.svh"

// ----------------------------------------------------------------------------
// Torque friction blend
// Per-tick torque law: input low-pass filters, friction blending with velocity
// damping, output saturation and peak-hold indicator followers.
// ----------------------------------------------------------------------------
module torque_friction_blend #(
    parameter int CV_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_we,
    input  wire logic [tfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tfb_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire tfb_pkg::in_t                   in_data,

    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      tfb_pkg::out_t                  out_data
);

    import tfb_pkg::*;

    // The sequencer steps through the products one state per cycle and holds in
    // S_WB_PKL until the output register is free. A step named after a product also
    // writes back the product of the step before it, if any, which waits in prod_reg.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_CV0,
        S_MUL_CV1,
        S_MUL_DAMP,
        S_MUL_PRIM,
        S_MUL_FRIC,
        S_WB_DRIVE,
        S_MUL_PKH,
        S_MUL_PKL,
        S_WB_PKL
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic        cv0_gain_mode_reg, cv0_gain_mode_next;
    logic        cv1_mode_reg, cv1_mode_next;
    logic [15:0] filter_alpha_reg, filter_alpha_next;
    logic [15:0] indicator_alpha_reg, indicator_alpha_next;
    logic [15:0] damping_gain_reg, damping_gain_next;

    // Filter and follower state.
    logic signed [23:0] cv0f_reg, cv0f_next;
    logic signed [23:0] cv1f_reg, cv1f_next;
    logic signed [19:0] pkh_reg, pkh_next;
    logic signed [19:0] pkl_reg, pkl_next;

    // Output register.
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;

    // Working registers of the current beat.
    logic signed [15:0] cv1q_reg;
    logic signed [23:0] vel_reg;
    logic signed [19:0] target0_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] damp_reg;
    logic signed [17:0] t1_reg;
    logic signed [19:0] drive_reg;

    // ------------------------------------------------------------------------
    // Input conversion to Q.15. Narrow converters are scaled up, wide ones are
    // shifted down with the upper field bits reading as zero.
    // ------------------------------------------------------------------------
    logic signed [15:0] cv0_q15, cv1_q15;

    if (CV_BITS < 16) begin : g_cv_narrow
        assign cv0_q15 = $signed({in_data.cv0_sample[CV_BITS-1:0], {(16 - CV_BITS){1'b0}}});
        assign cv1_q15 = $signed({in_data.cv1_sample[CV_BITS-1:0], {(16 - CV_BITS){1'b0}}});
    end else if (CV_BITS == 16) begin : g_cv_native
        assign cv0_q15 = in_data.cv0_sample;
        assign cv1_q15 = in_data.cv1_sample;
    end else begin : g_cv_wide
        assign cv0_q15 = $signed($unsigned(in_data.cv0_sample) >> (CV_BITS - 16));
        assign cv1_q15 = $signed($unsigned(in_data.cv1_sample) >> (CV_BITS - 16));
    end

    // Gain of ten on the first voltage as two shifted adds.
    logic signed [19:0] cv0_x10;
    logic signed [19:0] target0_in;

    assign cv0_x10    = (20'(cv0_q15) <<< 3) + (20'(cv0_q15) <<< 1);
    assign target0_in = cv0_gain_mode_reg ? cv0_x10 : 20'(cv0_q15);

    // ------------------------------------------------------------------------
    // Derived operands.
    // ------------------------------------------------------------------------
    logic signed [24:0] prim_sum;
    logic signed [16:0] primary;
    logic signed [16:0] cv1_ext;
    logic signed [16:0] fric;
    logic signed [16:0] one_minus_fric;
    logic signed [19:0] drive_pos, drive_neg;

    assign prim_sum = 25'(cv0f_reg) + (cv1_mode_reg ? 25'(cv1f_reg) : 25'sd0);

    always_comb
    begin
        if (prim_sum > 25'(ONE_Q15))
        begin
            primary = ONE_Q15;
        end
        else if (prim_sum < 25'(NEG_ONE_Q15))
        begin
            primary = NEG_ONE_Q15;
        end
        else
        begin
            primary = 17'(prim_sum);
        end
    end

    // The magnitude of a Q.15 sample never exceeds unity, so full negative
    // input yields exactly full friction without a separate limit.
    assign cv1_ext        = 17'(cv1q_reg);
    assign fric           = cv1_mode_reg ? 17'sd0 : ((cv1_ext < 0) ? -cv1_ext : cv1_ext);
    assign one_minus_fric = ONE_Q15 - fric;

    assign drive_pos = (drive_reg > 0) ? drive_reg : 20'sd0;
    assign drive_neg = (drive_reg < 0) ? drive_reg : 20'sd0;

    // ------------------------------------------------------------------------
    // Shared multiplier and its operand select.
    // ------------------------------------------------------------------------
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;

    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 18'sd0;
        case (state_reg)
            S_MUL_CV0:
            begin
                mul_a = 33'(target0_reg) - 33'(cv0f_reg);
                mul_b = $signed({2'b00, filter_alpha_reg});
            end
            S_MUL_CV1:
            begin
                mul_a = 33'(cv1q_reg) - 33'(cv1f_reg);
                mul_b = $signed({2'b00, filter_alpha_reg});
            end
            S_MUL_DAMP:
            begin
                mul_a = 33'(vel_reg);
                mul_b = $signed({2'b00, damping_gain_reg});
            end
            S_MUL_PRIM:
            begin
                mul_a = 33'(primary);
                mul_b = 18'(one_minus_fric);
            end
            S_MUL_FRIC:
            begin
                mul_a = 33'(damp_reg);
                mul_b = 18'(fric);
            end
            S_MUL_PKH:
            begin
                mul_a = 33'(drive_pos) - 33'(pkh_reg);
                mul_b = $signed({2'b00, indicator_alpha_reg});
            end
            S_MUL_PKL:
            begin
                mul_a = 33'(drive_neg) - 33'(pkl_reg);
                mul_b = $signed({2'b00, indicator_alpha_reg});
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------------
    // Write-back arithmetic. All right shifts are arithmetic, which floors.
    // ------------------------------------------------------------------------
    logic signed [33:0] drive_raw;
    logic signed [19:0] drive_sat;
    logic signed [21:0] pkh_sum, pkl_sum;
    logic signed [19:0] pkh_sat, pkl_sat;

    assign drive_raw = 34'(t1_reg) - 34'(prod_reg >>> 15);

    always_comb
    begin
        if (drive_raw > 34'(TORQUE_MAX))
        begin
            drive_sat = TORQUE_MAX;
        end
        else if (drive_raw < 34'(TORQUE_MIN))
        begin
            drive_sat = TORQUE_MIN;
        end
        else
        begin
            drive_sat = 20'(drive_raw);
        end
    end

    assign pkh_sum = 22'(pkh_reg) + 22'(prod_reg >>> 16);
    assign pkl_sum = 22'(pkl_reg) + 22'(prod_reg >>> 16);

    always_comb
    begin
        if (pkh_sum < 0)
        begin
            pkh_sat = 20'sd0;
        end
        else if (pkh_sum > 22'(TORQUE_MAX))
        begin
            pkh_sat = TORQUE_MAX;
        end
        else
        begin
            pkh_sat = 20'(pkh_sum);
        end

        if (pkl_sum > 0)
        begin
            pkl_sat = 20'sd0;
        end
        else if (pkl_sum < 22'(TORQUE_MIN))
        begin
            pkl_sat = TORQUE_MIN;
        end
        else
        begin
            pkl_sat = 20'(pkl_sum);
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer and next-state logic.
    // ------------------------------------------------------------------------
    logic in_fire;
    logic out_slot_free;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign out_slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next           = state_reg;
        cv0_gain_mode_next   = cv0_gain_mode_reg;
        cv1_mode_next        = cv1_mode_reg;
        filter_alpha_next    = filter_alpha_reg;
        indicator_alpha_next = indicator_alpha_reg;
        damping_gain_next    = damping_gain_reg;
        cv0f_next            = cv0f_reg;
        cv1f_next            = cv1f_reg;
        pkh_next             = pkh_reg;
        pkl_next             = pkl_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        out_data_next        = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_CV0_GAIN_MODE:   cv0_gain_mode_next   = cfg_data[0];
                REG_CV1_MODE:        cv1_mode_next        = cfg_data[0];
                REG_FILTER_ALPHA:    filter_alpha_next    = cfg_data[15:0];
                REG_INDICATOR_ALPHA: indicator_alpha_next = cfg_data[15:0];
                REG_DAMPING_GAIN:    damping_gain_next    = cfg_data[15:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MUL_CV0;
                end
            end
            S_MUL_CV0:
            begin
                state_next = S_MUL_CV1;
            end
            S_MUL_CV1:
            begin
                cv0f_next  = cv0f_reg + 24'(prod_reg >>> 16);
                state_next = S_MUL_DAMP;
            end
            S_MUL_DAMP:
            begin
                cv1f_next  = cv1f_reg + 24'(prod_reg >>> 16);
                state_next = S_MUL_PRIM;
            end
            S_MUL_PRIM:
            begin
                state_next = S_MUL_FRIC;
            end
            S_MUL_FRIC:
            begin
                state_next = S_WB_DRIVE;
            end
            S_WB_DRIVE:
            begin
                state_next = S_MUL_PKH;
            end
            S_MUL_PKH:
            begin
                state_next = S_MUL_PKL;
            end
            S_MUL_PKL:
            begin
                pkh_next   = pkh_sat;
                state_next = S_WB_PKL;
            end
            S_WB_PKL:
            begin
                // The last follower update and the result load happen together,
                // once the output register can take the beat.
                if (out_slot_free)
                begin
                    pkl_next                       = pkl_sat;
                    out_valid_next                 = 1'b1;
                    out_data_next.drive_torque     = drive_reg;
                    out_data_next.torque_peak_high = pkh_reg[18:0];
                    out_data_next.torque_peak_low  = pkl_sat;
                    state_next                     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration, filter state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            cv0_gain_mode_reg   <= 1'b0;
            cv1_mode_reg        <= 1'b0;
            filter_alpha_reg    <= FILTER_ALPHA_RESET;
            indicator_alpha_reg <= INDICATOR_ALPHA_RESET;
            damping_gain_reg    <= DAMPING_GAIN_RESET;
            cv0f_reg            <= '0;
            cv1f_reg            <= '0;
            pkh_reg             <= '0;
            pkl_reg             <= '0;
            out_valid_reg       <= 1'b0;
            out_data_reg        <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            cv0_gain_mode_reg   <= cv0_gain_mode_next;
            cv1_mode_reg        <= cv1_mode_next;
            filter_alpha_reg    <= filter_alpha_next;
            indicator_alpha_reg <= indicator_alpha_next;
            damping_gain_reg    <= damping_gain_next;
            cv0f_reg            <= cv0f_next;
            cv1f_reg            <= cv1f_next;
            pkh_reg             <= pkh_next;
            pkl_reg             <= pkl_next;
            out_valid_reg       <= out_valid_next;
            out_data_reg        <= out_data_next;
        end
    end

    // Working registers of the current beat; they carry no control meaning.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cv1q_reg    <= cv1_q15;
            vel_reg     <= in_data.motor_velocity;
            target0_reg <= target0_in;
        end
        // The product is held while the last step waits for the output side.
        if (state_reg != S_WB_PKL)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_MUL_PRIM)
        begin
            damp_reg <= 32'(prod_reg >>> 8);
        end
        if (state_reg == S_MUL_FRIC)
        begin
            t1_reg <= 18'(prod_reg >>> 15);
        end
        if (state_reg == S_WB_DRIVE)
        begin
            drive_reg <= drive_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `TFB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
    `TFB_ASSERT_ALWAYS(a_peak_high_nonneg, clk, rst_n, pkh_reg >= 0)
    `TFB_ASSERT_ALWAYS(a_peak_low_nonpos, clk, rst_n, pkl_reg <= 0)
    `TFB_ASSERT_IMPL(a_result_from_last_step, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_WB_PKL))

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Torque friction blend testbench
// Sends control voltage and velocity beats through the valid/ready input and
// checks every result beat against an in-bench model of the torque law. The
// model covers the input low-pass filters, friction blending, saturation and
// the peak followers. The run covers directed corner cases, register decode,
// a long output stall, a drained pause and a random sweep over register
// settings. By default both sides idle at random between beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfb_pkg::*;

    // Indexes past the end of the register map. Writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

    // Extra cycles to wait after the last result.
    localparam int SETTLE_CYCLES = 12;

    // Each phase of the random sweep sends this many beats.
    localparam int SWEEP_PHASES     = 8;
    localparam int BEATS_PER_PHASE  = 175;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    logic  [CFG_INDEX_W-1:0] cfg_index;
    logic  [CFG_DATA_W-1:0]  cfg_data;
    logic  in_valid;
    logic  in_ready;
    in_t   in_data;
    logic  out_valid;
    logic  out_ready;
    out_t  out_data;

    torque_friction_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The model's copy of the register file. It is updated on every write the
    // bench makes, and writes to unmapped indexes are dropped.
    logic        gain_ten_mode;
    logic        cv1_sum_mode;
    logic [15:0] lowpass_alpha;
    logic [15:0] follower_alpha;
    logic [15:0] damping_scale;

    // The model's copy of the block state. It is kept wide so that no
    // intermediate value wraps.
    longint cv0_level;
    longint cv1_level;
    longint peak_high_level;
    longint peak_low_level;

    // Results predicted but not yet seen, oldest first.
    out_t pending_torque[$];
    int   error_count;

    // Idle controls shared by the test tasks and the two sides of the bench.
    bit   sender_idles;
    bit   receiver_idles;
    int   receiver_hold_cycles;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The slowest correct run is about 1600 beats plus the long output hold.
    // That is near 1 ms, so 10 ms leaves a wide margin.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the torque law
    // ------------------------------------------------------------------------

    // One-pole follower step. The product is floored by the arithmetic shift.
    function automatic longint follow_step(longint level, longint target,
                                           logic [15:0] alpha);
        return level + ((longint'(alpha) * (target - level)) >>> 16);
    endfunction

    function automatic longint limit(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Advances the model state by one tick and returns the result beat the
    // block should produce for this input beat.
    function automatic out_t predict_torque(in_t beat);
        longint cv0;
        longint cv1;
        longint velocity;
        longint primary;
        longint friction;
        longint damping;
        longint drive;
        out_t   result;

        cv0      = longint'(beat.cv0_sample);
        cv1      = longint'(beat.cv1_sample);
        velocity = longint'(beat.motor_velocity);

        cv0_level = follow_step(cv0_level, gain_ten_mode ? cv0 * 10 : cv0, lowpass_alpha);
        cv1_level = follow_step(cv1_level, cv1, lowpass_alpha);

        primary = cv0_level;
        if (cv1_sum_mode)
            primary += cv1_level;
        primary = limit(primary, longint'(NEG_ONE_Q15), longint'(ONE_Q15));

        // Friction uses the raw second voltage. Full negative scale gives exactly one.
        if (cv1_sum_mode)
            friction = 0;
        else
            friction = limit(cv1 < 0 ? -cv1 : cv1, 0, longint'(ONE_Q15));

        damping = (velocity * longint'(damping_scale)) >>> 8;
        drive   = ((primary * (longint'(ONE_Q15) - friction)) >>> 15)
                - ((damping * friction) >>> 15);
        drive   = limit(drive, longint'(TORQUE_MIN), longint'(TORQUE_MAX));

        peak_high_level = follow_step(peak_high_level, drive > 0 ? drive : 0,
                                      follower_alpha);
        peak_low_level  = follow_step(peak_low_level, drive < 0 ? drive : 0,
                                      follower_alpha);
        peak_high_level = limit(peak_high_level, 0, longint'(TORQUE_MAX));
        peak_low_level  = limit(peak_low_level, longint'(TORQUE_MIN), 0);

        result.drive_torque     = drive[19:0];
        result.torque_peak_high = peak_high_level[18:0];
        result.torque_peak_low  = peak_low_level[19:0];
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Beat construction
    // ------------------------------------------------------------------------
    function automatic in_t make_beat(int cv0, int cv1, int velocity);
        in_t beat;
        beat.cv0_sample     = 16'(cv0);
        beat.cv1_sample     = 16'(cv1);
        beat.motor_velocity = 24'(velocity);
        return beat;
    endfunction

    // Control voltages lean toward full scale and zero, because clamping and
    // full friction happen there. The rest are spread over the whole range.
    function automatic int random_cv();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return int'($urandom_range(0, 8191)) - 4096;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic in_t random_beat();
        int velocity;
        case ($urandom_range(0, 4))
            0:       velocity = $urandom_range(0, 1) ? 8388607 : -8388608;
            1, 2:    velocity = int'($urandom);
            default: velocity = int'($urandom_range(0, 131071)) - 65536;
        endcase
        return make_beat(random_cv(), random_cv(), velocity);
    endfunction

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offers one beat, waits until it is accepted, and then records its
    // prediction. Valid stays high after acceptance. The next call, or a drain,
    // decides whether it drops, so valid is never lowered and raised in the
    // same step.
    task automatic send_beat(input in_t beat);
        int gap;
        gap = sender_idles ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        pending_torque.push_back(predict_torque(beat));
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_beat(random_beat());
    endtask

    // Drops valid and waits until every predicted result has come back, then
    // waits a little longer so that the block is truly idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_torque.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A register write holds the enable high for a single cycle and then low before it
    // returns. Back-to-back writes therefore never assign the enable twice in one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (index)
            REG_CV0_GAIN_MODE:   gain_ten_mode  = data[0];
            REG_CV1_MODE:        cv1_sum_mode   = data[0];
            REG_FILTER_ALPHA:    lowpass_alpha  = data;
            REG_INDICATOR_ALPHA: follower_alpha = data;
            REG_DAMPING_GAIN:    damping_scale  = data;
            default:             ;
        endcase
    endtask

    task automatic apply_settings(input logic gain_ten, input logic sum_mode,
                                  input logic [15:0] lp_alpha,
                                  input logic [15:0] peak_alpha,
                                  input logic [15:0] damping);
        write_reg(REG_CV0_GAIN_MODE, {15'd0, gain_ten});
        write_reg(REG_CV1_MODE, {15'd0, sum_mode});
        write_reg(REG_FILTER_ALPHA, lp_alpha);
        write_reg(REG_INDICATOR_ALPHA, peak_alpha);
        write_reg(REG_DAMPING_GAIN, damping);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: draws a stall before each result beat. A test can also ask it
    // to hold ready low for a long stretch, which it counts in its own loop.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (receiver_hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (receiver_hold_cycles) @(posedge clk);
                receiver_hold_cycles = 0;
            end
            stall = receiver_idles ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Every accepted result beat is compared with the oldest
    // prediction, one field at a time.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_result
        out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_torque.size() == 0) begin
                $error("result beat arrived with no prediction waiting");
                error_count++;
            end else begin
                want = pending_torque.pop_front();
                if (out_data.drive_torque !== want.drive_torque) begin
                    $error("drive_torque mismatch: expected %0d, actual %0d",
                           want.drive_torque, out_data.drive_torque);
                    error_count++;
                end
                if (out_data.torque_peak_high !== want.torque_peak_high) begin
                    $error("torque_peak_high mismatch: expected %0d, actual %0d",
                           want.torque_peak_high, out_data.torque_peak_high);
                    error_count++;
                end
                if (out_data.torque_peak_low !== want.torque_peak_low) begin
                    $error("torque_peak_low mismatch: expected %0d, actual %0d",
                           want.torque_peak_low, out_data.torque_peak_low);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases under the reset settings and then under extreme settings:
    // full-scale voltages, full negative second voltage (full friction, so no
    // primary term), gain of ten, sum mode clamping, saturation from heavy
    // damping, and alpha of zero, where filters and followers hold.
    task automatic test_directed_corners();
        send_beat(make_beat(32767, 0, 0));
        send_beat(make_beat(-32768, 0, 0));
        send_beat(make_beat(0, -32768, 8388607));
        send_beat(make_beat(0, 32767, -8388608));
        send_beat(make_beat(32767, -32768, 0));
        drain();

        // Fast filters, gain of ten and the largest damping. The velocity term
        // drives the torque into both saturation limits.
        apply_settings(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(make_beat(32767, 0, 0));
        send_beat(make_beat(-32768, 0, 0));
        send_beat(make_beat(0, -32768, 8388607));
        send_beat(make_beat(0, -32768, -8388608));
        send_beat(make_beat(32767, 16384, 8388607));
        drain();

        // Sum mode: both voltages push past unity in each direction.
        apply_settings(1'b0, 1'b1, 16'hFFFF, 16'd1311, 16'd256);
        send_beat(make_beat(32767, 32767, 8388607));
        send_beat(make_beat(-32768, -32768, -8388608));
        send_beat(make_beat(32767, -32768, 0));
        drain();

        // Alpha of zero: both filters and both followers freeze where they are.
        apply_settings(1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        send_beat(make_beat(-32768, 32767, 8388607));
        send_beat(make_beat(32767, -32768, -8388608));
        send_beat(make_beat(0, 0, 0));
        drain();
    endtask

    // Writes to indexes past the map must change nothing. For the one-bit
    // registers, only the lowest data bit counts.
    task automatic test_register_decode();
        for (int idx = REG_UNMAPPED_FIRST; idx <= REG_UNMAPPED_LAST; idx++)
            write_reg(CFG_INDEX_W'(idx), 16'hFFFF);
        write_reg(REG_CV0_GAIN_MODE, 16'hFFFE);
        write_reg(REG_CV1_MODE, 16'hFFFE);
        write_reg(REG_FILTER_ALPHA, FILTER_ALPHA_RESET);
        write_reg(REG_INDICATOR_ALPHA, INDICATOR_ALPHA_RESET);
        write_reg(REG_DAMPING_GAIN, DAMPING_GAIN_RESET);
        send_random(6);
        drain();
        write_reg(REG_CV0_GAIN_MODE, 16'h0003);
        write_reg(REG_CV1_MODE, 16'h8001);
        send_random(6);
        drain();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // beats. The block fills and must hold off its input without losing data.
    task automatic test_output_holdoff();
        apply_settings(1'b0, 1'b0, 16'd4000, 16'd8000, 16'd512);
        receiver_hold_cycles = 400;
        sender_idles = 1'b0;
        send_random(40);
        sender_idles = 1'b1;
        drain();
    endtask

    // The sender stops partway until every result is back, then resumes. The
    // filter state must carry across the idle gap.
    task automatic test_sender_pause();
        send_random(20);
        drain();
        send_random(20);
        drain();
    endtask

    // Random beats under a series of register settings, with the extremes
    // among them. Idling varies by phase, so some phases run with no gaps
    // on one side, but none with no gaps on both.
    task automatic test_random_sweep();
        for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
            case (phase)
                0: apply_settings(1'b0, 1'b0, FILTER_ALPHA_RESET,
                                  INDICATOR_ALPHA_RESET, DAMPING_GAIN_RESET);
                1: apply_settings(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: apply_settings(1'b0, 1'b1, 16'd0, 16'd0, 16'd0);
                3: apply_settings(1'b1, 1'b1, 16'hFFFF, 16'd1, 16'd256);
                default: apply_settings(1'($urandom), 1'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom));
            endcase
            sender_idles   = (phase % 3) != 1;
            receiver_idles = (phase % 4) != 2;
            send_random(BEATS_PER_PHASE);
            drain();
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;

        // The model starts from the reset state of the block.
        gain_ten_mode        = 1'b0;
        cv1_sum_mode         = 1'b0;
        lowpass_alpha        = FILTER_ALPHA_RESET;
        follower_alpha       = INDICATOR_ALPHA_RESET;
        damping_scale        = DAMPING_GAIN_RESET;
        cv0_level            = 0;
        cv1_level            = 0;
        peak_high_level      = 0;
        peak_low_level       = 0;
        error_count          = 0;
        sender_idles         = 1'b1;
        receiver_idles       = 1'b1;
        receiver_hold_cycles = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_register_decode();
        test_output_holdoff();
        test_sender_pause();
        test_random_sweep();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

/* torque_friction_blend.f */
+incdir+hdl
hdl/tfb_pkg.sv
hdl/torque_friction_blend.sv
test/tb.sv
